### design/rdc_pkg.sv
`timescale 1ns / 1ps

package rdc_pkg;

	// Field widths
	localparam int VALUE_W = 31;
	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	// Digit stack sizing
	localparam int STACK_DEPTH = 32;
	localparam int STK_AW      = $clog2(STACK_DEPTH);
	localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

	// Divider: DIV_BITS quotient bits per cycle
	localparam int DIV_BITS = 8;
	localparam int DIV_CYC  = (VALUE_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_W    = DIV_CYC * DIV_BITS;
	localparam int DIV_CW   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

	// Radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	// ASCII codes
	localparam logic [CHAR_W-1:0]  ASC_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  ASC_A    = 7'h41;
	localparam logic [DIGIT_W-1:0] DEC_TEN  = DIGIT_W'(10);

	// Stack command from the sequencer
	typedef struct packed {
		logic               push;
		logic               pop;
		logic [DIGIT_W-1:0] wdata;
	} stk_cmd_t;

	// Stack status back to the sequencer
	typedef struct packed {
		logic empty;
		logic full;
	} stk_stat_t;

	// Clamp the programmed radix to 2..16
	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

	// Map a digit to '0'..'9' or 'A'..'F'
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d >= DEC_TEN) begin
			res = ASC_A + CHAR_W'(d - DEC_TEN);
		end else begin
			res = ASC_ZERO + CHAR_W'(d);
		end
		return res;
	endfunction

endpackage

### design/radix_digit_converter_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_ready    value[30:0]
// output    out_valid / out_ready  digit_char[6:0], last_digit
// config    cfg_wr_en              cfg_wr_data[4:0] (radix)
//
// Each digit is one restoring divide in the shared divider, then a hand-off
// that pushes the remainder; each character is popped through the digit
// stack's registered read (ST_POP_RD, ST_POP_LD, ST_POP_WAIT). An item has
// D digits, with D in 1..31.
// in_ready is high only while idle; a stalled output holds the sequencer.
// Reset clears the sequencer, the stack count and sets radix to 10.

module radix_digit_converter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rdc_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last_digit,
	input  logic                        cfg_wr_en,
	input  logic [rdc_pkg::RADIX_W-1:0] cfg_wr_data
);
	import rdc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_POP_RD,
		ST_POP_LD,
		ST_POP_WAIT
	} state_t;

	state_t             state_q;
	logic [RADIX_W-1:0] radix_q;
	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic               in_acc;
	logic               div_start;
	logic [VALUE_W-1:0] div_dividend;
	logic               div_done;
	logic [VALUE_W-1:0] div_quot;
	logic [DIGIT_W-1:0] div_rem;
	logic               more;
	stk_cmd_t           stk_cmd;
	stk_stat_t          stk_stat;
	logic [DIGIT_W-1:0] stk_rdata;

	// Radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign more     = (div_quot != '0);

	// Start a divide on accept, and again while the quotient is nonzero
	assign div_start    = in_acc || (state_q == ST_DIV && div_done && more);
	assign div_dividend = (state_q == ST_IDLE) ? value : div_quot;

	// Push each remainder, pop one digit per character
	always_comb begin
		stk_cmd.push  = (state_q == ST_DIV) && div_done;
		stk_cmd.pop   = (state_q == ST_POP_RD);
		stk_cmd.wdata = div_rem;
	end

	rdc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (eff_radix(radix_q)),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	rdc_digit_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.stat   (stk_stat),
		.rdata  (stk_rdata)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done && !more) begin
						state_q <= ST_POP_RD;
					end
				end
				ST_POP_RD: begin
					state_q <= ST_POP_LD;
				end
				ST_POP_LD: begin
					char_q      <= digit_to_ascii(stk_rdata);
					last_q      <= stk_stat.empty;
					out_valid_q <= 1'b1;
					state_q     <= ST_POP_WAIT;
				end
				ST_POP_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= last_q ? ST_IDLE : ST_POP_RD;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

endmodule

### design/rdc_divider.sv
`timescale 1ns / 1ps

module rdc_divider (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rdc_pkg::VALUE_W-1:0] dividend,
	input  logic [rdc_pkg::RADIX_W-1:0] divisor,
	output logic                        done,
	output logic [rdc_pkg::VALUE_W-1:0] quotient,
	output logic [rdc_pkg::DIGIT_W-1:0] remainder
);
	import rdc_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic [DIV_W-1:0]    work_q;
	logic [RADIX_W-1:0]  rem_q;
	logic [DIV_W-1:0]    work_n;
	logic [RADIX_W-1:0]  rem_n;
	logic [RADIX_W:0]    trial;

	// Restoring division, DIV_BITS quotient bits per cycle
	always_comb begin
		work_n = work_q;
		rem_n  = rem_q;
		trial  = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial  = {rem_n, work_n[DIV_W-1]};
			work_n = {work_n[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_n     = RADIX_W'(trial - {1'b0, divisor});
				work_n[0] = 1'b1;
			end else begin
				rem_n = trial[RADIX_W-1:0];
			end
		end
	end

	// Load on start, iterate while busy, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CW'(1);
				if (cnt_q == DIV_CW'(DIV_CYC - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {(DIV_W - VALUE_W)'(0), dividend};
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_n;
			rem_q  <= rem_n;
		end
	end

	assign done      = done_q;
	assign quotient  = work_q[VALUE_W-1:0];
	assign remainder = rem_q[DIGIT_W-1:0];

endmodule

### design/rdc_digit_stack.sv
`timescale 1ns / 1ps

module rdc_digit_stack (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rdc_pkg::stk_cmd_t           cmd,
	output rdc_pkg::stk_stat_t          stat,
	output logic [rdc_pkg::DIGIT_W-1:0] rdata
);
	import rdc_pkg::*;

	logic [DIGIT_W-1:0] mem [STACK_DEPTH];
	logic [STK_CW-1:0]  count_q;
	logic [STK_CW-1:0]  top_idx;
	logic [DIGIT_W-1:0] rdata_q;
	logic               full;

	assign full    = (count_q == STK_CW'(STACK_DEPTH));
	assign top_idx = count_q - STK_CW'(1);

	// Track fill level; drop a push when full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push && !full) begin
			count_q <= count_q + STK_CW'(1);
		end else if (cmd.pop && count_q != '0) begin
			count_q <= top_idx;
		end
	end

	// Write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			mem[count_q[STK_AW-1:0]] <= cmd.wdata;
		end
		if (cmd.pop) begin
			rdata_q <= mem[top_idx[STK_AW-1:0]];
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.full  = full;
	assign rdata      = rdata_q;

endmodule
